// File: src/mrect_pkg.sv
// ----------------------------------------------------------------------------
// mrect_pkg
// Shared constants for the largest all-ones rectangle finder: the field
// widths of the stream channels, the configuration register and the area
// saturation limit.
// ----------------------------------------------------------------------------
`default_nettype none

package mrect_pkg;

    // Result field and its saturation value.
    localparam int AREA_W   = 17;
    localparam logic [AREA_W-1:0] AREA_MAX = 17'h1FFFF;

    // Row width register.
    localparam int CFG_W = 9;
    localparam logic [CFG_W-1:0] ROW_WIDTH_RESET = 9'd256;

    // Stream data widths, padded to whole bytes.
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;

endpackage

`default_nettype wire

// File: src/maximal_rectangle_of_ones.sv
// ----------------------------------------------------------------------------
// maximal_rectangle_of_ones
// Largest all-ones rectangle in a binary image streamed in row-major order.
// The slave channel carries one pixel per item (s_tdata bit 0) and s_tlast
// marks the last pixel of the image. The master channel carries one item per
// image, the largest rectangle area in cells, saturated at 131071.
// cfg_wr_en / cfg_wr_data set the row width (0 acts as 1, values above
// MAX_WIDTH act as MAX_WIDTH); write it only while the block is idle.
// A pixel is accepted, its column height is read, updated and written back,
// and it is then compared with the stack top and pushed; each stack entry it
// pops adds a stack read and a pop step, since the entry below the top comes
// from the registered stack memory read. At row end the stack is flushed with
// a read and a pop step per entry; after the last row the result is registered.
// After reset, and after every frame, the column height memory is cleared in
// a pass over all MAX_WIDTH entries during which no pixel is accepted.
// The result waits in an output register. If it has not been taken when the
// next frame completes, the block holds before clearing until it is.
// ----------------------------------------------------------------------------
`default_nettype none

module maximal_rectangle_of_ones
    import mrect_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // Configuration: row width.
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_W-1:0]     cfg_wr_data,
    // Pixel stream.
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // [0] pixel, [7:1] zero
    input  wire logic                 s_tlast,   // frame_end
    // Result stream.
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata    // [16:0] max_area, [23:17] zero
);

    // Derived widths.
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;  // column index
    localparam int SW = $clog2(MAX_WIDTH + 1);                    // stack count
    localparam int HW = $clog2(MAX_HEIGHT + 1);                   // height
    localparam int WW = (CW + 1 > CFG_W + 1) ? CW + 1 : CFG_W + 1; // width compare
    localparam int PW = HW + CW + 1;                              // product
    localparam int XW = (PW > AREA_W) ? PW : AREA_W;
    localparam int EW = CW + HW;                                  // stack entry

    // State codes.
    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_HEIGHT = 3'd2;
    localparam logic [2:0] ST_POPCHK = 3'd3;
    localparam logic [2:0] ST_POPRD  = 3'd4;
    localparam logic [2:0] ST_FLUSH  = 3'd5;
    localparam logic [2:0] ST_FIN    = 3'd6;

    // Memories.
    logic [HW-1:0] height_mem [MAX_WIDTH];
    logic [EW-1:0] stack_mem  [MAX_WIDTH];

    // Control registers.
    logic [2:0]        state_reg, state_next;
    logic [SW-1:0]     count_reg, count_next;
    logic [CW-1:0]     col_reg, col_next;
    logic [AREA_W-1:0] best_reg, best_next;
    logic [CFG_W-1:0]  rw_reg;
    logic              out_valid_reg, out_valid_next;
    logic              prod_valid_reg, prod_valid_next;
    logic [CW-1:0]     clr_reg, clr_next;
    logic              flush_reg, flush_next;

    // Payload registers.
    logic [CW-1:0]     top_col_reg, top_col_next;
    logic [HW-1:0]     top_h_reg, top_h_next;
    logic [HW-1:0]     cur_h_reg, cur_h_next;
    logic              pixel_reg, pixel_next;
    logic              last_reg, last_next;
    logic [PW-1:0]     prod_reg, prod_next;
    logic [AREA_W-1:0] out_data_reg, out_data_next;

    // Memory ports.
    logic          h_rd_en, h_wr_en;
    logic [CW-1:0] h_rd_addr, h_wr_addr;
    logic [HW-1:0] h_wr_data, h_rdata;
    logic          s_rd_en, s_wr_en;
    logic [CW-1:0] s_rd_addr, s_wr_addr;
    logic [EW-1:0] s_wr_data, s_rdata;

    // Datapath helpers.
    logic              in_fire;
    logic [WW-1:0]     act_w;
    logic              row_done;
    logic [HW:0]       h_inc;
    logic [HW-1:0]     h_new;
    logic [CW:0]       right;
    logic [CW:0]       left1;
    logic [CW:0]       span;
    logic [CW-1:0]     below_col;
    logic [XW-1:0]     prod_ext;
    logic [AREA_W-1:0] prod_sat;
    logic [AREA_W-1:0] best_upd;

    assign in_fire  = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - AREA_W){1'b0}}, out_data_reg};

    // Effective row width after clamping.
    always_comb
    begin
        if (rw_reg == '0)
            act_w = WW'(1);
        else if (WW'(rw_reg) > WW'(MAX_WIDTH))
            act_w = WW'(MAX_WIDTH);
        else
            act_w = WW'(rw_reg);
    end

    assign row_done = last_reg || ((WW'(col_reg) + WW'(1)) >= act_w);

    // New column height: add one on a set pixel, saturating; clear otherwise.
    assign h_inc = {1'b0, h_rdata} + (HW + 1)'(1);
    always_comb
    begin
        if (!pixel_reg)
            h_new = '0;
        else if (h_inc > (HW + 1)'(MAX_HEIGHT))
            h_new = HW'(MAX_HEIGHT);
        else
            h_new = h_inc[HW-1:0];
    end

    // Rectangle width of the popped entry.
    assign below_col = s_rdata[EW-1:HW];
    assign right     = flush_reg ? ({1'b0, col_reg} + (CW + 1)'(1)) : {1'b0, col_reg};
    assign left1     = (count_reg >= SW'(2)) ? ({1'b0, below_col} + (CW + 1)'(1)) : '0;
    assign span      = right - left1;

    // Saturated area and running maximum.
    assign prod_ext = XW'(prod_reg);
    assign prod_sat = (prod_ext > XW'(AREA_MAX)) ? AREA_MAX : prod_ext[AREA_W-1:0];
    assign best_upd = (prod_valid_reg && (prod_sat > best_reg)) ? prod_sat : best_reg;

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        col_next        = col_reg;
        best_next       = best_upd;
        out_valid_next  = out_valid_reg;
        prod_valid_next = 1'b0;
        clr_next        = clr_reg;
        flush_next      = flush_reg;
        top_col_next    = top_col_reg;
        top_h_next      = top_h_reg;
        cur_h_next      = cur_h_reg;
        pixel_next      = pixel_reg;
        last_next       = last_reg;
        prod_next       = prod_reg;
        out_data_next   = out_data_reg;
        h_rd_en         = 1'b0;
        h_rd_addr       = col_reg;
        h_wr_en         = 1'b0;
        h_wr_addr       = col_reg;
        h_wr_data       = h_new;
        s_rd_en         = 1'b0;
        s_rd_addr       = CW'(count_reg - SW'(2));
        s_wr_en         = 1'b0;
        s_wr_addr       = CW'(count_reg - SW'(1));
        s_wr_data       = {top_col_reg, top_h_reg};

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            // Clear the column heights, one entry per cycle.
            ST_CLEAR:
            begin
                h_wr_en   = 1'b1;
                h_wr_addr = clr_reg;
                h_wr_data = '0;
                clr_next  = clr_reg + CW'(1);
                if (clr_reg == CW'(MAX_WIDTH - 1))
                begin
                    clr_next   = '0;
                    state_next = ST_IDLE;
                end
            end

            // Take a pixel and fetch the height of its column.
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    pixel_next = s_tdata[0];
                    last_next  = s_tlast;
                    h_rd_en    = 1'b1;
                    state_next = ST_HEIGHT;
                end
            end

            // Write back the updated height.
            ST_HEIGHT:
            begin
                h_wr_en    = 1'b1;
                cur_h_next = h_new;
                state_next = ST_POPCHK;
            end

            // Pop while the top is not lower; otherwise push this column.
            ST_POPCHK:
            begin
                if ((count_reg != '0) && (top_h_reg >= cur_h_reg))
                begin
                    s_rd_en    = 1'b1;
                    flush_next = 1'b0;
                    state_next = ST_POPRD;
                end
                else
                begin
                    if (count_reg != '0)
                        s_wr_en = 1'b1;
                    top_col_next = col_reg;
                    top_h_next   = cur_h_reg;
                    count_next   = count_reg + SW'(1);
                    if (row_done)
                    begin
                        flush_next = 1'b1;
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        col_next   = col_reg + CW'(1);
                        state_next = ST_IDLE;
                    end
                end
            end

            // The entry below the top has arrived: form the area and pop.
            ST_POPRD:
            begin
                prod_next       = PW'(top_h_reg * span);
                prod_valid_next = 1'b1;
                top_col_next    = below_col;
                top_h_next      = s_rdata[HW-1:0];
                count_next      = count_reg - SW'(1);
                state_next      = flush_reg ? ST_FLUSH : ST_POPCHK;
            end

            // Empty the stack at row end.
            ST_FLUSH:
            begin
                if (count_reg != '0)
                begin
                    s_rd_en    = 1'b1;
                    state_next = ST_POPRD;
                end
                else
                begin
                    col_next   = '0;
                    flush_next = 1'b0;
                    state_next = last_reg ? ST_FIN : ST_IDLE;
                end
            end

            // Emit the best area once the output register is free.
            ST_FIN:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = best_upd;
                    best_next      = '0;
                    count_next     = '0;
                    col_next       = '0;
                    clr_next       = '0;
                    state_next     = ST_CLEAR;
                end
            end

            default:
            begin
                state_next = ST_CLEAR;
                clr_next   = '0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            count_reg      <= '0;
            col_reg        <= '0;
            best_reg       <= '0;
            rw_reg         <= ROW_WIDTH_RESET;
            out_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
            clr_reg        <= '0;
            flush_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            col_reg        <= col_next;
            best_reg       <= best_next;
            out_valid_reg  <= out_valid_next;
            prod_valid_reg <= prod_valid_next;
            clr_reg        <= clr_next;
            flush_reg      <= flush_next;
            if (cfg_wr_en)
                rw_reg <= cfg_wr_data;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        top_col_reg  <= top_col_next;
        top_h_reg    <= top_h_next;
        cur_h_reg    <= cur_h_next;
        pixel_reg    <= pixel_next;
        last_reg     <= last_next;
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
    end

    // Column height memory.
    always_ff @(posedge clk)
    begin
        if (h_wr_en)
            height_mem[h_wr_addr] <= h_wr_data;
        if (h_rd_en)
            h_rdata <= height_mem[h_rd_addr];
    end

    // Stack memory: entries below the top, as column and height.
    always_ff @(posedge clk)
    begin
        if (s_wr_en)
            stack_mem[s_wr_addr] <= s_wr_data;
        if (s_rd_en)
            s_rdata <= stack_mem[s_rd_addr];
    end

endmodule

`default_nettype wire

// File: src/mrect_checker.sv
// ----------------------------------------------------------------------------
// mrect_checker
// Port-level checks for the largest all-ones rectangle finder, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mrect_checker
    import mrect_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Padding bits of the result stay zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[M_TDATA_W-1:AREA_W] == '0))
        else $error("result padding not zero");

    // The block leaves the idle state on each accepted pixel, so no item is taken right after another.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted in back-to-back cycles");

    // A new result starts the clearing pass, so input is held off.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !s_tready)
        else $error("input ready while a new result appears");

endmodule

bind maximal_rectangle_of_ones mrect_checker u_mrect_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
